// ===== hdl/slb_pkg.sv =====
`timescale 1ns / 1ps

package slb_pkg;

  localparam int NumLinesDef  = 8;
  localparam int LineBytesDef = 20;
  localparam int QueueDepth   = 2;

  localparam int InDataW  = 16;
  localparam int InUserW  = 2;
  localparam int OutDataW = 24;
  localparam int OutUserW = 3;

  localparam logic [7:0] NewlineCode = 8'h0A;

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STORED      = 3'd0,
    ST_LINE_DONE   = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_ACCESS_DONE = 3'd4
  } status_e;

  // Classified item handed from the front end to the executing back end
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
    logic       is_newline;
    logic [2:0] sel;
    logic [4:0] pos;
    logic       sel_ok;
    logic       pos_ok;
  } op_t;

endpackage

// ===== hdl/slb_front.sv =====
`timescale 1ns / 1ps

module slb_front #(
  parameter int NUM_LINES  = slb_pkg::NumLinesDef,
  parameter int LINE_BYTES = slb_pkg::LineBytesDef
) (
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // rx_byte[7:0], buffer_sel[10:8], position[15:11]
  input  logic [slb_pkg::InDataW-1:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [slb_pkg::InUserW-1:0] s_axis_tuser_i,
  output logic                        push_valid_o,
  output slb_pkg::op_t                push_op_o,
  input  logic                        push_ready_i
);

  logic [7:0] rx_byte;
  logic [2:0] sel;
  logic [4:0] pos;

  assign rx_byte = s_axis_tdata_i[7:0];
  assign sel     = s_axis_tdata_i[10:8];
  assign pos     = s_axis_tdata_i[15:11];

  always_comb begin
    push_op_o.cmd        = slb_pkg::cmd_e'(s_axis_tuser_i);
    push_op_o.rx_byte    = rx_byte;
    push_op_o.is_newline = (rx_byte == slb_pkg::NewlineCode);
    push_op_o.sel        = sel;
    push_op_o.pos        = pos;
    // range checks settled here so the back end only indexes
    push_op_o.sel_ok     = (int'(sel) < NUM_LINES);
    push_op_o.pos_ok     = (int'(pos) < LINE_BYTES);
  end

  assign push_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = push_ready_i;

endmodule

// ===== hdl/slb_queue.sv =====
`timescale 1ns / 1ps

module slb_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  slb_pkg::op_t push_op_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output slb_pkg::op_t pop_op_o,
  input  logic         pop_ready_i
);

  localparam int PtrW = $clog2(slb_pkg::QueueDepth);
  localparam int CntW = $clog2(slb_pkg::QueueDepth + 1);

  slb_pkg::op_t    entry_q [slb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(slb_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(slb_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(slb_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // clear the slots so the back end never decodes an undefined command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < slb_pkg::QueueDepth; i++) begin
        entry_q[i] <= '0;
      end
    end else if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== hdl/slb_back.sv =====
`timescale 1ns / 1ps

module slb_back #(
  parameter int NUM_LINES  = slb_pkg::NumLinesDef,
  parameter int LINE_BYTES = slb_pkg::LineBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  input  slb_pkg::op_t                 pop_op_i,
  output logic                         pop_ready_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // line_buffer[2:0], line_length[7:3], busy_mask[15:8], read_byte[23:16]
  output logic [slb_pkg::OutDataW-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [slb_pkg::OutUserW-1:0] m_axis_tuser_o
);

  localparam int Total = NUM_LINES * LINE_BYTES;
  localparam int AddrW = $clog2(Total);
  localparam int WbW   = $clog2(NUM_LINES);
  localparam int FcW   = $clog2(LINE_BYTES + 1);

  logic [7:0]           line_store_q [Total];
  logic [NUM_LINES-1:0] busy_q, busy_d;
  logic [WbW-1:0]       wb_q, wb_d, shown_wb;
  logic [AddrW-1:0]     base_q, base_d;
  logic [FcW-1:0]       fill_q, fill_d, len_d;
  logic                 done_line;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr, rd_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic                 pop;
  logic                 out_valid_q;
  slb_pkg::status_e     status_d, status_q;
  logic [31:0]          wb_wide, len_wide;
  logic [7:0]           mask_d, mask_q;
  logic [2:0]           line_buf_q;
  logic [4:0]           line_len_q;
  logic                 rd_ok_q;
  logic [7:0]           rd_q;

  assign pop_ready_o = !out_valid_q || m_axis_tready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  assign wr_addr = base_q + AddrW'(fill_q);
  assign rd_addr = AddrW'(int'(pop_op_i.sel) * LINE_BYTES + int'(pop_op_i.pos));
  assign rd_en   = (pop_op_i.cmd == slb_pkg::CMD_READ) && pop_op_i.sel_ok && pop_op_i.pos_ok;

  always_comb begin
    busy_d    = busy_q;
    wb_d      = wb_q;
    base_d    = base_q;
    fill_d    = fill_q;
    len_d     = '0;
    done_line = 1'b0;
    wr_en     = 1'b0;
    wr_data   = pop_op_i.rx_byte;
    status_d  = slb_pkg::ST_ACCESS_DONE;
    unique case (pop_op_i.cmd)
      slb_pkg::CMD_RECEIVE: begin
        if (busy_q[wb_q]) begin
          status_d = slb_pkg::ST_NO_FREE;
        end else if (fill_q < FcW'(LINE_BYTES)) begin
          wr_en = 1'b1;
          if (pop_op_i.is_newline) begin
            // terminate, mark busy and move round the ring
            wr_data      = 8'h00;
            busy_d[wb_q] = 1'b1;
            len_d        = fill_q;
            done_line    = 1'b1;
            fill_d       = '0;
            status_d     = slb_pkg::ST_LINE_DONE;
            if (wb_q == WbW'(NUM_LINES - 1)) begin
              wb_d   = '0;
              base_d = '0;
            end else begin
              wb_d   = wb_q + 1'b1;
              base_d = base_q + AddrW'(LINE_BYTES);
            end
          end else begin
            fill_d   = fill_q + 1'b1;
            status_d = slb_pkg::ST_STORED;
          end
        end else begin
          // drop the partial line
          fill_d   = '0;
          status_d = slb_pkg::ST_OVERFLOW;
        end
      end
      slb_pkg::CMD_RELEASE: begin
        if (pop_op_i.sel_ok) begin
          for (int i = 0; i < NUM_LINES; i++) begin
            if (int'(pop_op_i.sel) == i) begin
              busy_d[i] = 1'b0;
            end
          end
        end
      end
      slb_pkg::CMD_READ, slb_pkg::CMD_UNUSED: begin
      end
    endcase
  end

  assign shown_wb = done_line ? wb_q : wb_d;
  assign wb_wide  = 32'(shown_wb);
  assign len_wide = 32'(len_d);

  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < NUM_LINES) begin : g_used
      assign mask_d[g] = busy_d[g];
    end else begin : g_unused
      assign mask_d[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      wb_q        <= '0;
      base_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else if (pop) begin
      busy_q      <= busy_d;
      wb_q        <= wb_d;
      base_q      <= base_d;
      fill_q      <= fill_d;
      out_valid_q <= 1'b1;
      rd_ok_q     <= rd_en;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q   <= status_d;
      line_buf_q <= wb_wide[2:0];
      line_len_q <= len_wide[4:0];
      mask_q     <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && wr_en) begin
      line_store_q[wr_addr] <= wr_data;
    end
    if (pop && rd_en) begin
      rd_q <= line_store_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(rd_ok_q ? rd_q : 8'h00), mask_q, line_len_q, line_buf_q};
  assign m_axis_tuser_o  = status_q;

endmodule

// ===== hdl/serial_line_buffer_ring.sv =====
`timescale 1ns / 1ps

// Ring of NUM_LINES line buffers of LINE_BYTES bytes, filled from a serial receiver.
// Slave channel: one command per transfer, cmd in tuser (receive, read, release);
// rx_byte, buffer_sel and position in tdata. A newline closes the current line,
// marks its buffer busy and advances the ring; read returns a stored byte and
// release frees a buffer.
// Master channel: exactly one result per command, status in tuser; line_buffer,
// line_length, busy_mask and read_byte in tdata.
// A command waits in a queue slot, then in the output register, until its result is
// valid. Throughput, while results are accepted, is one command per cycle, set by the
// single write/read port of the line store, which the back end uses once per command.
// A two-entry queue separates decode from execution, so a stalled receiver first
// fills the queue and then drops s_axis_tready_o; results wait in the output register.
// Reset empties the queue, frees all buffers and restarts at buffer 0, position 0;
// the line store itself keeps no reset value and needs no clearing pass.
module serial_line_buffer_ring #(
  parameter int NUM_LINES  = slb_pkg::NumLinesDef,
  parameter int LINE_BYTES = slb_pkg::LineBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // rx_byte[7:0], buffer_sel[10:8], position[15:11]
  input  logic [slb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  logic [slb_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // line_buffer[2:0], line_length[7:3], busy_mask[15:8], read_byte[23:16]
  output logic [slb_pkg::OutDataW-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [slb_pkg::OutUserW-1:0] m_axis_tuser_o
);

  logic         push_valid, push_ready;
  slb_pkg::op_t push_op;
  logic         pop_valid, pop_ready;
  slb_pkg::op_t pop_op;

  slb_front #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_valid_o    (push_valid),
    .push_op_o       (push_op),
    .push_ready_i    (push_ready)
  );

  slb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_op_o     (pop_op),
    .pop_ready_i  (pop_ready)
  );

  slb_back #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_op_i        (pop_op),
    .pop_ready_o     (pop_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // only a read returns a byte
  a_read_byte_only_on_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[23:16] != 8'h00)
      |-> (m_axis_tuser_o == slb_pkg::ST_ACCESS_DONE))
    else $error("read byte shown on a non-access result");

  // a length is reported only for a completed line
  a_length_only_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[7:3] != 5'd0)
      |-> (m_axis_tuser_o == slb_pkg::ST_LINE_DONE))
    else $error("line length shown without a completed line");

  // a completed line leaves its buffer busy
  a_done_marks_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == slb_pkg::ST_LINE_DONE) && (NUM_LINES <= 8)
      |-> m_axis_tdata_o[8 + m_axis_tdata_o[2:0]])
    else $error("completed line buffer not marked busy");

  // the input side only stalls once both decode slots are taken
  a_no_stall_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> pop_valid)
    else $error("input stalled with an empty queue");

endmodule

// ===== test/line_ring_checker.sv =====
`timescale 1ns / 1ps

module line_ring_checker (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  input  logic                                          in_ready_i,
  input  logic [slb_pkg::InDataW-1:0]                   in_data_i,
  input  logic [slb_pkg::InUserW-1:0]                   in_user_i,
  input  logic                                          out_valid_i,
  input  logic                                          out_ready_i,
  input  logic [slb_pkg::OutDataW-1:0]                  out_data_i,
  input  logic [slb_pkg::OutUserW-1:0]                  out_user_i,
  output int                                            fail_count_o,
  output int                                            pending_o,
  output logic [slb_pkg::NumLinesDef-1:0]               busy_map_o,
  output logic [slb_pkg::NumLinesDef*slb_pkg::LineBytesDef-1:0] written_map_o
);

  localparam int NumLines   = slb_pkg::NumLinesDef;
  localparam int LineBytes  = slb_pkg::LineBytesDef;
  localparam int StoreBytes = NumLines * LineBytes;

  typedef struct packed {
    slb_pkg::status_e status;
    logic [2:0]       line_id;
    logic [4:0]       len;
    logic [7:0]       busy;
    logic [7:0]       rd;
  } line_result_t;

  logic [7:0]            line_mem [StoreBytes];
  logic [StoreBytes-1:0] written;
  logic [NumLines-1:0]   busy;
  logic [2:0]            wr_line;
  logic [4:0]            fill;
  line_result_t          expected_results [$];
  int                    fails = 0;

  // Advance the shadow ring by one command and return the result it must give
  function automatic line_result_t step_line_ring(slb_pkg::cmd_e cmd, logic [7:0] rx,
                                                  logic [2:0] sel, logic [4:0] pos);
    line_result_t r;
    int           addr;
    logic [2:0]   done_line;
    r = '0;
    r.status = slb_pkg::ST_ACCESS_DONE;
    done_line = wr_line;
    unique case (cmd)
      slb_pkg::CMD_RECEIVE: begin
        if (busy[wr_line]) begin
          r.status = slb_pkg::ST_NO_FREE;
        end else if (fill < LineBytes) begin
          addr = int'(wr_line) * LineBytes + int'(fill);
          written[addr] = 1'b1;
          if (rx == slb_pkg::NewlineCode) begin
            line_mem[addr] = 8'h00;
            busy[wr_line] = 1'b1;
            r.len = fill;
            r.status = slb_pkg::ST_LINE_DONE;
            wr_line = (int'(wr_line) == NumLines - 1) ? 3'd0 : wr_line + 3'd1;
            fill = '0;
          end else begin
            line_mem[addr] = rx;
            fill = fill + 5'd1;
            r.status = slb_pkg::ST_STORED;
          end
        end else begin
          // line too long: throw away the partial line
          fill = '0;
          r.status = slb_pkg::ST_OVERFLOW;
        end
      end
      slb_pkg::CMD_READ: begin
        if (pos < LineBytes) r.rd = line_mem[int'(sel) * LineBytes + int'(pos)];
      end
      slb_pkg::CMD_RELEASE: busy[sel] = 1'b0;
      default: ;
    endcase
    r.line_id = (r.status == slb_pkg::ST_LINE_DONE) ? done_line : wr_line;
    r.busy = busy;
    return r;
  endfunction

  task automatic report_field(string name, int want_v, int got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t got;
    line_result_t want;
    if (!rst_ni) begin
      busy = '0;
      wr_line = '0;
      fill = '0;
      written = '0;
      expected_results.delete();
      pending_o <= 0;
      busy_map_o <= '0;
      written_map_o <= '0;
    end else begin
      // compare before queuing this edge's command
      if (out_valid_i && out_ready_i) begin
        got.status  = slb_pkg::status_e'(out_user_i);
        got.line_id = out_data_i[2:0];
        got.len     = out_data_i[7:3];
        got.busy    = out_data_i[15:8];
        got.rd      = out_data_i[23:16];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d data %h",
                   $time, out_user_i, out_data_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) report_field("status", want.status, got.status);
          if (got.line_id !== want.line_id)
            report_field("line_buffer", want.line_id, got.line_id);
          if (got.len !== want.len) report_field("line_length", want.len, got.len);
          if (got.busy !== want.busy) report_field("busy_mask", want.busy, got.busy);
          if (got.rd !== want.rd) report_field("read_byte", want.rd, got.rd);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(step_line_ring(slb_pkg::cmd_e'(in_user_i),
                                                  in_data_i[7:0], in_data_i[10:8],
                                                  in_data_i[15:11]));
      pending_o <= expected_results.size();
      busy_map_o <= busy;
      written_map_o <= written;
    end
    fail_count_o <= fails;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int ItemTarget = 800;
  localparam int HoldStart  = 40;
  localparam int HoldCycles = 200;
  localparam int LineBytes  = slb_pkg::LineBytesDef;
  localparam int StoreBytes = slb_pkg::NumLinesDef * slb_pkg::LineBytesDef;

  logic                         clk_i    = 1'b0;
  logic                         rst_ni   = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [slb_pkg::InDataW-1:0]  s_tdata  = '0;
  logic [slb_pkg::InUserW-1:0]  s_tuser  = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [slb_pkg::OutDataW-1:0] m_tdata;
  logic [slb_pkg::OutUserW-1:0] m_tuser;

  int                             fail_count;
  int                             pending;
  logic [slb_pkg::NumLinesDef-1:0] busy_map;
  logic [StoreBytes-1:0]          written_map;

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int rx_cycles      = 0;

  serial_line_buffer_ring uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  line_ring_checker line_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .in_data_i     (s_tdata),
    .in_user_i     (s_tuser),
    .out_valid_i   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_data_i    (m_tdata),
    .out_user_i    (m_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .busy_map_o    (busy_map),
    .written_map_o (written_map)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [slb_pkg::InDataW-1:0] pack_in(logic [7:0] rx, logic [2:0] sel,
                                                          logic [4:0] pos);
    return {pos, sel, rx};
  endfunction

  // Offer one command and hold it until the transfer completes
  task automatic send_item(slb_pkg::cmd_e cmd, logic [slb_pkg::InDataW-1:0] data);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] rx);
    send_item(slb_pkg::CMD_RECEIVE,
              pack_in(rx, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))));
  endtask

  function automatic int line_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 18);
    if (r < 95) return LineBytes - 1;
    return $urandom_range(LineBytes, LineBytes + 3);
  endfunction

  task automatic send_line(int len);
    logic [7:0] rx;
    for (int i = 0; i < len; i++) begin
      do rx = 8'($urandom_range(0, 255)); while (rx == slb_pkg::NewlineCode);
      send_byte(rx);
    end
    send_byte(slb_pkg::NewlineCode);
  endtask

  // Mostly free a line that is waiting, so the ring keeps turning
  task automatic send_release();
    logic [2:0] sel;
    if (busy_map != '0 && $urandom_range(0, 3) != 0) begin
      do sel = 3'($urandom_range(0, 7)); while (!busy_map[sel]);
    end else begin
      sel = 3'($urandom_range(0, 7));
    end
    send_item(slb_pkg::CMD_RELEASE, pack_in(8'($urandom_range(0, 255)), sel,
                                            5'($urandom_range(0, 31))));
  endtask

  // Read only entries already written, or positions past the end of a line
  task automatic send_read();
    int   idx;
    int   tries;
    logic hit;
    hit = 1'b0;
    tries = 0;
    if ($urandom_range(0, 9) != 0) begin
      while (!hit && tries < 12) begin
        idx = $urandom_range(0, StoreBytes - 1);
        hit = written_map[idx];
        tries++;
      end
    end
    if (hit)
      send_item(slb_pkg::CMD_READ, pack_in(8'($urandom_range(0, 255)), 3'(idx / LineBytes),
                                           5'(idx % LineBytes)));
    else
      send_item(slb_pkg::CMD_READ, pack_in(8'($urandom_range(0, 255)),
                                           3'($urandom_range(0, 7)),
                                           5'($urandom_range(LineBytes, 31))));
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(slb_pkg::CMD_UNUSED, slb_pkg::InDataW'($urandom_range(0, 65535)));
    else
      send_byte(8'($urandom_range(0, 255)));
  endtask

  // Result side: one long hold-off early on, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cycles++;
      if (rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldCycles)
        m_tready <= 1'b0;
      else
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    int pick;
    int wait_cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(slb_pkg::CMD_READ, pack_in(8'h00, 3'd7, 5'd25));
    send_item(slb_pkg::CMD_UNUSED, '1);
    send_item(slb_pkg::CMD_RELEASE, pack_in(8'h00, 3'd3, 5'd0));
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(slb_pkg::NewlineCode);
    send_item(slb_pkg::CMD_READ, pack_in(8'h00, 3'd0, 5'd0));
    send_item(slb_pkg::CMD_READ, pack_in(8'h00, 3'd0, 5'd3));
    // terminator of the first line
    send_item(slb_pkg::CMD_READ, pack_in(8'h00, 3'd0, 5'd4));
    send_item(slb_pkg::CMD_READ, pack_in(8'hFF, 3'd0, 5'd31));
    // empty line into buffer 1
    send_byte(slb_pkg::NewlineCode);
    send_item(slb_pkg::CMD_RELEASE, pack_in(8'hFF, 3'd0, 5'd31));
    send_item(slb_pkg::CMD_RELEASE, pack_in(8'h00, 3'd0, 5'd0));

    while (items_sent < ItemTarget) begin
      unique case (items_sent * 4 / ItemTarget)
        0: begin
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct = 48;
          sink_stall_pct = 0;
        end
        2: begin
          src_gap_pct = 0;
          sink_stall_pct = 48;
        end
        default: begin
          src_gap_pct = 23;
          sink_stall_pct = 23;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 40) send_line(line_len());
      else if (pick < 75) send_release();
      else if (pick < 93) send_read();
      else send_noise();
    end
    s_tvalid <= 1'b0;

    // let the count of outstanding results catch up with the last transfer
    @(posedge clk_i);
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
